/* hdl/rtcb_pkg.sv */
// ----------------------------------------------------------------------------
// rtcb_pkg
// Shared types, codes and BCD helpers for the real-time clock register file.
// ----------------------------------------------------------------------------
package rtcb_pkg;

    localparam int REG_COUNT = 19;
    localparam int IDX_W     = $clog2(REG_COUNT);

    // command codes
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_INC    = 3'd2;
    localparam logic [2:0] CMD_AMPM   = 3'd3;
    localparam logic [2:0] CMD_MODE   = 3'd4;

    // time register addresses
    localparam logic [4:0] ADDR_SEC   = 5'd0;
    localparam logic [4:0] ADDR_MIN   = 5'd1;
    localparam logic [4:0] ADDR_HOUR  = 5'd2;
    localparam logic [4:0] ADDR_WDAY  = 5'd3;
    localparam logic [4:0] ADDR_DATE  = 5'd4;
    localparam logic [4:0] ADDR_MONTH = 5'd5;
    localparam logic [4:0] ADDR_YEAR  = 5'd6;

    // hour format codes (hours bits 6:5)
    localparam logic [1:0] FMT_AM     = 2'd2;
    localparam logic [1:0] FMT_PM     = 2'd3;

    localparam logic [7:0] MASK_12H   = 8'd31;
    localparam logic [7:0] MASK_MONTH = 8'd127;
    localparam logic [7:0] MASK_AM    = 8'd95;
    localparam logic [7:0] BITS_AM    = 8'd64;
    localparam logic [7:0] BITS_PM    = 8'd96;
    localparam logic [7:0] NOON       = 8'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return 8'((hi << 3) + (hi << 1)) + {4'b0, b[3:0]};
    endfunction

    // divide by ten through the reciprocal 205/2048, exact below 1029
    function automatic logic [7:0] dec_bcd(input logic [7:0] d);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 16'(d) * 16'd205;
        q    = prod[15:11];
        r    = d - 8'(({3'b0, q} << 3) + ({3'b0, q} << 1));
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] d, input logic [7:0] wrap_at,
                                        input logic [7:0] restart);
        logic [7:0] n;
        n = d + 8'd1;
        return (n == wrap_at) ? restart : n;
    endfunction

    function automatic logic [7:0] inc_hours(input logic [7:0] v);
        logic [7:0] n;
        if (v[6:5] < FMT_AM)
            return dec_bcd(bump(bcd_dec(v), 8'd24, 8'd0));
        n = dec_bcd(bump(bcd_dec(v & MASK_12H), 8'd13, 8'd1));
        return n | ((v[6:5] == FMT_PM) ? BITS_PM : BITS_AM);
    endfunction

    function automatic logic [7:0] inc_field(input logic [4:0] a, input logic [7:0] v);
        logic [7:0] res;
        unique case (a)
            ADDR_SEC, ADDR_MIN: res = dec_bcd(bump(bcd_dec(v), 8'd60, 8'd0));
            ADDR_HOUR:          res = inc_hours(v);
            ADDR_WDAY:          res = dec_bcd(bump(bcd_dec(v), 8'd8, 8'd1));
            ADDR_DATE:          res = dec_bcd(bump(bcd_dec(v), 8'd32, 8'd1));
            ADDR_MONTH:         res = dec_bcd(bump(bcd_dec(v & MASK_MONTH), 8'd13, 8'd1));
            ADDR_YEAR:          res = dec_bcd(bump(bcd_dec(v), 8'd100, 8'd0));
            default:            res = v;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] toggle_ampm(input logic [7:0] v);
        logic [7:0] res;
        priority if (v[6:5] == FMT_PM)
            res = v & MASK_AM;
        else if (v[6])
            res = v | BITS_PM;
        else
            res = v;
        return res;
    endfunction

    function automatic logic [7:0] toggle_mode(input logic [7:0] v);
        logic [7:0] d;
        logic [7:0] res;
        if (v[6:5] < FMT_AM) begin
            d = bcd_dec(v);
            priority if (d == 8'd0)
                res = dec_bcd(NOON) | BITS_AM;
            else if (d == NOON)
                res = dec_bcd(NOON) | BITS_PM;
            else if (d > NOON)
                res = dec_bcd(d - NOON) | BITS_PM;
            else
                res = dec_bcd(d) | BITS_AM;
        end
        else begin
            d = bcd_dec(v & MASK_12H);
            if (v[6:5] == FMT_AM)
                res = (d == NOON) ? 8'd0 : (v & MASK_12H);
            else
                res = (d == NOON) ? dec_bcd(NOON) : dec_bcd(d + NOON);
        end
        return res;
    endfunction

endpackage

/* hdl/rtc_bcd_time_register_adjust_top.sv */
// ----------------------------------------------------------------------------
// rtc_bcd_time_register_adjust_top
// BCD real-time clock register file with write, read, field increment and
// 12/24-hour and AM/PM toggles.
// ----------------------------------------------------------------------------
// Each request transaction yields one response transaction carrying the
// addressed register after the command (the hours register for the toggles)
// and the hour format code. A request is first captured into the request
// registers, then executed, updating the register file and loading the
// response register; the next request is taken in the same cycle that the
// response is taken, so the block holds off a new request until the last
// response is taken. All registers read as zero after reset.
module rtc_bcd_time_register_adjust_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] cmd,
    input  logic [4:0] reg_addr,
    input  logic [7:0] write_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] read_data,
    output logic [1:0] hour_format
);
    import rtcb_pkg::*;

    dp_cmd_t dp_cmd;

    rtcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_cmd    (dp_cmd)
    );

    rtcb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .cmd         (cmd),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .read_data   (read_data),
        .hour_format (hour_format)
    );

    // an accepted request is executed before any response is offered
    a_exec_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> !rsp_valid)
        else $error("response offered during execute cycle");

    // an accepted request always produces a response once it has passed through execute
    a_rsp_due: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> ##2 rsp_valid)
        else $error("response missing after accepted request");

    // execute and capture never coincide
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.exec && dp_cmd.load))
        else $error("request captured while executing");

endmodule

/* hdl/rtcb_ctrl.sv */
// ----------------------------------------------------------------------------
// rtcb_ctrl
// Sequencer: capture a request, execute it, hold the response until taken.
// ----------------------------------------------------------------------------
module rtcb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rtcb_pkg::dp_cmd_t dp_cmd
);
    import rtcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = ST_DONE;
            ST_DONE:
                if (!rsp_stall)
                    state_next = req_valid ? ST_EXEC : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // take a request while idle, or in the cycle the response leaves
    always_comb
    begin
        req_stall   = !((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && !rsp_stall));
        rsp_valid   = (state_reg == ST_DONE);
        dp_cmd.load = req_valid && !req_stall;
        dp_cmd.exec = (state_reg == ST_EXEC);
    end

endmodule

/* hdl/rtcb_dp.sv */
// ----------------------------------------------------------------------------
// rtcb_dp
// Register file, request capture, BCD update logic and response register.
// ----------------------------------------------------------------------------
module rtcb_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  rtcb_pkg::dp_cmd_t dp_cmd,
    input  logic [2:0]        cmd,
    input  logic [4:0]        reg_addr,
    input  logic [7:0]        write_data,
    output logic [7:0]        read_data,
    output logic [1:0]        hour_format
);
    import rtcb_pkg::*;

    logic [7:0] regs_reg [REG_COUNT];
    logic [2:0] cmd_reg;
    logic [4:0] addr_reg;
    logic [7:0] data_reg;
    logic [7:0] read_data_reg;
    logic [1:0] hour_format_reg;

    logic       addr_ok;
    logic [7:0] cur_val;
    logic [7:0] hours_val;
    logic       wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0] wr_val;
    logic [7:0] rsp_data_next;
    logic [1:0] rsp_fmt_next;

    localparam logic [IDX_W-1:0] HOUR_IDX = ADDR_HOUR[IDX_W-1:0];

    assign addr_ok   = {1'b0, addr_reg} < 6'(REG_COUNT);
    assign cur_val   = addr_ok ? regs_reg[addr_reg[IDX_W-1:0]] : 8'd0;
    assign hours_val = regs_reg[HOUR_IDX];

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = addr_reg[IDX_W-1:0];
        wr_val = data_reg;
        unique case (cmd_reg)
            CMD_WRITE:
                wr_en = addr_ok;
            CMD_INC:
            begin
                wr_en  = addr_ok;
                wr_val = inc_field(addr_reg, cur_val);
            end
            CMD_AMPM:
            begin
                wr_en  = 1'b1;
                wr_idx = HOUR_IDX;
                wr_val = toggle_ampm(hours_val);
            end
            CMD_MODE:
            begin
                wr_en  = 1'b1;
                wr_idx = HOUR_IDX;
                wr_val = toggle_mode(hours_val);
            end
            default:
                wr_en = 1'b0;   // read and unused codes
        endcase
    end

    assign rsp_data_next = wr_en ? wr_val : cur_val;
    assign rsp_fmt_next  = (wr_en && (wr_idx == HOUR_IDX)) ? wr_val[6:5] : hours_val[6:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= 8'd0;
        end
        else if (dp_cmd.exec && wr_en) begin
            regs_reg[wr_idx] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load) begin
            cmd_reg  <= cmd;
            addr_reg <= reg_addr;
            data_reg <= write_data;
        end
        if (dp_cmd.exec) begin
            read_data_reg   <= rsp_data_next;
            hour_format_reg <= rsp_fmt_next;
        end
    end

    assign read_data   = read_data_reg;
    assign hour_format = hour_format_reg;

endmodule

/* verif/rtc_bcd_time_register_adjust_top_test.sv */
// ----------------------------------------------------------------------------
// rtc_bcd_time_register_adjust_top_test
// Self-checking bench for the BCD clock register file. A directed table covers
// reset contents, wrap points, the hour mode conversions and bad addresses.
// A long random run follows, mostly well-formed clock values with increments.
// Every response is checked against the table's expected values or a local model.
// Both handshakes see random idle bursts and one long response hold.
// ----------------------------------------------------------------------------
module rtc_bcd_time_register_adjust_top_test;

    import rtcb_pkg::*;

    localparam int         RANDOM_ITEMS  = 1520;
    localparam int         QUIET_FROM    = 1350;
    localparam int         HOLD_AT       = 500;
    localparam int         HOLD_CYCLES   = 60;
    localparam int         WATCHDOG_MAX  = 1000;
    localparam int         TAIL_CYCLES   = 8;
    localparam int         REPORT_MAX    = 200;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam logic [4:0] ADDR_LAST     = 5'(REG_COUNT - 1);
    localparam logic [4:0] ADDR_BAD_LO   = 5'(REG_COUNT);
    localparam logic [4:0] ADDR_BAD_HI   = 5'd31;
    localparam logic [1:0] FMT_24H       = 2'd0;
    localparam logic [1:0] FMT_24H_B5    = 2'd1;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] hour_format;
    } clock_reply_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [4:0]   addr;
        logic [7:0]   data;
        logic         typed;
        clock_reply_t reply;
    } dir_row_t;

    localparam int DIR_ROWS = 29;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic [2:0] cmd;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
    logic       rsp_valid;
    logic       rsp_stall;
    logic [7:0] read_data;
    logic [1:0] hour_format;

    logic [7:0]   clock_regs [REG_COUNT];
    clock_reply_t expected_replies [$];
    int           errors;
    int           idle_count;
    int           tx_rate;
    int           rx_rate;
    bit           hold_rsp;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_READ,     ADDR_SEC,    8'h00, 1'b1, '{8'h00, FMT_24H}},
        '{CMD_READ,     ADDR_BAD_HI, 8'h3c, 1'b1, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_BAD_LO, 8'h55, 1'b1, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_SEC,    8'h59, 1'b1, '{8'h59, FMT_24H}},
        '{CMD_INC,      ADDR_SEC,    8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_MIN,    8'hff, 1'b1, '{8'hff, FMT_24H}},
        '{CMD_INC,      ADDR_MIN,    8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_HOUR,   8'h23, 1'b1, '{8'h23, FMT_24H_B5}},
        '{CMD_INC,      ADDR_HOUR,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_MODE,     ADDR_SEC,    8'h00, 1'b1, '{8'h52, FMT_AM}},
        '{CMD_AMPM,     ADDR_SEC,    8'h00, 1'b1, '{8'h72, FMT_PM}},
        '{CMD_MODE,     ADDR_SEC,    8'h00, 1'b1, '{8'h12, FMT_24H}},
        '{CMD_WRITE,    ADDR_HOUR,   8'h71, 1'b1, '{8'h71, FMT_PM}},
        '{CMD_INC,      ADDR_HOUR,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_WDAY,   8'h07, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_INC,      ADDR_WDAY,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_DATE,   8'h31, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_INC,      ADDR_DATE,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_MONTH,  8'h92, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_INC,      ADDR_MONTH,  8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_YEAR,   8'h99, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_INC,      ADDR_YEAR,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_LAST,   8'ha5, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_INC,      ADDR_LAST,   8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_SPARE_HI, ADDR_DATE,   8'hff, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_WRITE,    ADDR_HOUR,   8'h15, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_MODE,     ADDR_SEC,    8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_MODE,     ADDR_SEC,    8'h00, 1'b0, '{8'h00, FMT_24H}},
        '{CMD_AMPM,     ADDR_SEC,    8'h00, 1'b0, '{8'h00, FMT_24H}}
    };

    rtc_bcd_time_register_adjust_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_data   (read_data),
        .hour_format (hour_format)
    );

    // ------------------------------------------------------------------
    // clock register model
    // ------------------------------------------------------------------
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        return 8'(b[7:4] * 10 + b[3:0]);
    endfunction

    function automatic logic [7:0] bin_to_bcd(input logic [7:0] d);
        int unsigned tens;
        int unsigned units;
        tens  = d / 10;
        units = d % 10;
        return 8'((tens << 4) | units);
    endfunction

    function automatic logic [7:0] step_up(input logic [7:0] d, input logic [7:0] wrap_at,
                                           input logic [7:0] restart);
        logic [7:0] n;
        n = d + 8'd1;
        return (n == wrap_at) ? restart : n;
    endfunction

    function automatic logic [7:0] next_hours(input logic [7:0] v);
        logic [7:0] n;
        if (v[6:5] < FMT_AM)
            return bin_to_bcd(step_up(bcd_to_bin(v), 8'd24, 8'd0));
        n = bin_to_bcd(step_up(bcd_to_bin(v & MASK_12H), 8'd13, 8'd1));
        return n | ((v[6:5] == FMT_PM) ? BITS_PM : BITS_AM);
    endfunction

    function automatic logic [7:0] flip_hour_mode(input logic [7:0] v);
        logic [7:0] d;
        if (v[6:5] < FMT_AM)
        begin
            d = bcd_to_bin(v);
            if (d == 8'd0)
                return bin_to_bcd(NOON) | BITS_AM;
            if (d == NOON)
                return bin_to_bcd(NOON) | BITS_PM;
            if (d > NOON)
                return bin_to_bcd(d - NOON) | BITS_PM;
            return bin_to_bcd(d) | BITS_AM;
        end
        d = bcd_to_bin(v & MASK_12H);
        if (v[6:5] == FMT_AM)
            return (d == NOON) ? 8'd0 : (v & MASK_12H);
        if (d == NOON)
            return bin_to_bcd(NOON);
        return bin_to_bcd(d + NOON);
    endfunction

    function automatic clock_reply_t apply_command(input logic [2:0] op, input logic [4:0] a,
                                                   input logic [7:0] d);
        clock_reply_t r;
        logic         ok;
        logic [4:0]   shown;
        logic [7:0]   v;
        ok    = (a < REG_COUNT);
        shown = a;
        case (op)
            CMD_WRITE:
            begin
                if (ok)
                    clock_regs[a] = d;
            end
            CMD_INC:
            begin
                if (ok)
                begin
                    v = clock_regs[a];
                    case (a)
                        ADDR_SEC, ADDR_MIN: v = bin_to_bcd(step_up(bcd_to_bin(v), 8'd60, 8'd0));
                        ADDR_HOUR:          v = next_hours(v);
                        ADDR_WDAY:          v = bin_to_bcd(step_up(bcd_to_bin(v), 8'd8, 8'd1));
                        ADDR_DATE:          v = bin_to_bcd(step_up(bcd_to_bin(v), 8'd32, 8'd1));
                        ADDR_MONTH:
                            v = bin_to_bcd(step_up(bcd_to_bin(v & MASK_MONTH), 8'd13, 8'd1));
                        ADDR_YEAR:          v = bin_to_bcd(step_up(bcd_to_bin(v), 8'd100, 8'd0));
                        default:            ;
                    endcase
                    clock_regs[a] = v;
                end
            end
            CMD_AMPM:
            begin
                v = clock_regs[ADDR_HOUR];
                if ((v & BITS_PM) == BITS_PM)
                    v = v & MASK_AM;
                else if ((v & BITS_AM) == BITS_AM)
                    v = v | BITS_PM;
                clock_regs[ADDR_HOUR] = v;
                shown = ADDR_HOUR;
                ok    = 1'b1;
            end
            CMD_MODE:
            begin
                clock_regs[ADDR_HOUR] = flip_hour_mode(clock_regs[ADDR_HOUR]);
                shown = ADDR_HOUR;
                ok    = 1'b1;
            end
            default: ;
        endcase
        r.read_data   = ok ? clock_regs[shown] : 8'd0;
        r.hour_format = clock_regs[ADDR_HOUR][6:5];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly legal clock values, biased towards the wrap point
    function automatic logic [7:0] pick_write_byte(input logic [4:0] a);
        int lo;
        int hi;
        int d;
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        case (a)
            ADDR_SEC, ADDR_MIN: begin lo = 0; hi = 59; end
            ADDR_HOUR:
            begin
                if ($urandom_range(0, 1) == 0)
                    return bin_to_bcd(8'($urandom_range(0, 23)));
                return bin_to_bcd(8'($urandom_range(1, 12)))
                       | ($urandom_range(0, 1) ? BITS_PM : BITS_AM);
            end
            ADDR_WDAY:          begin lo = 1; hi = 7;  end
            ADDR_DATE:          begin lo = 1; hi = 31; end
            ADDR_MONTH:
            begin
                return bin_to_bcd(8'($urandom_range(1, 12))) | 8'($urandom_range(0, 1) << 7);
            end
            ADDR_YEAR:          begin lo = 0; hi = 99; end
            default:            return 8'($urandom);
        endcase
        d = $urandom_range(0, 1) ? hi - $urandom_range(0, 2) : $urandom_range(lo, hi);
        return bin_to_bcd(8'(d));
    endfunction

    function automatic logic [4:0] pick_addr(input int time_share);
        int r;
        r = $urandom_range(0, 99);
        if (r < time_share)
            return 5'($urandom_range(ADDR_SEC, ADDR_YEAR));
        if (r < 97)
            return 5'($urandom_range(ADDR_YEAR + 1, ADDR_LAST));
        return 5'($urandom_range(ADDR_BAD_LO, ADDR_BAD_HI));
    endfunction

    // offer one transaction and log its expected response once taken
    task automatic offer(input logic [2:0] op, input logic [4:0] a, input logic [7:0] d,
                         input logic typed, input clock_reply_t typed_reply);
        clock_reply_t r;
        if (tx_rate != 0 && $urandom_range(0, tx_rate) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid  <= 1'b1;
        cmd        <= op;
        reg_addr   <= a;
        write_data <= d;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        r = apply_command(op, a, d);
        expected_replies.push_back(typed ? typed_reply : r);
    endtask

    // ------------------------------------------------------------------
    // clock, reset and request side
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int         r;
        logic [2:0] op;
        logic [4:0] a;
        logic [7:0] d;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        cmd        <= CMD_READ;
        reg_addr   <= ADDR_SEC;
        write_data <= 8'd0;
        errors     = 0;
        tx_rate    = 0;
        rx_rate    = 0;
        hold_rsp   = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            clock_regs[i] = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data,
                  dir_rows[i].typed, dir_rows[i].reply);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_rate = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1)) ? 3 : 8);
                rx_rate = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1)) ? 3 : 8);
            end
            if (i >= QUIET_FROM)
            begin
                tx_rate = 0;
                rx_rate = 0;
            end
            if (i == HOLD_AT)
                hold_rsp = 1'b1;
            r = $urandom_range(0, 99);
            d = 8'($urandom);
            if (r < 25)
            begin
                op = CMD_WRITE;
                a  = pick_addr(85);
                d  = pick_write_byte(a);
            end
            else if (r < 45)
            begin
                op = CMD_READ;
                a  = pick_addr(85);
            end
            else if (r < 80)
            begin
                op = CMD_INC;
                a  = pick_addr(92);
            end
            else if (r < 89)
            begin
                op = CMD_AMPM;
                a  = 5'($urandom);
            end
            else if (r < 98)
            begin
                op = CMD_MODE;
                a  = 5'($urandom);
            end
            else
            begin
                op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                a  = 5'($urandom);
            end
            offer(op, a, d, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // response side: stall bursts and one long hold
    // ------------------------------------------------------------------
    initial
    begin
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (rx_rate != 0 && $urandom_range(0, rx_rate) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        clock_reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected response, got read_data %02h hour_format %0d",
                             $time, read_data, hour_format);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (read_data !== want.read_data)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, want.read_data, read_data);
                end
                if (hour_format !== want.hour_format)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: hour_format mismatch, expected %0d, actual %0d",
                                 $time, want.hour_format, hour_format);
                end
            end
        end
    end

    // drop out if no transaction moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_MAX)
        begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, expected_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
